// ----- rtl/gwm_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gwm_pkg
// Shared types and constants of the wildcard matcher: pattern characters,
// register indexes, bracket-class parse state carried along the cell chain.
// ----------------------------------------------------------------------------
package gwm_pkg;

    localparam int PATTERN_MAX_C = 16;
    localparam int PAT_BYTES     = 16;
    localparam int PAT_IDX_W     = $clog2(PAT_BYTES);
    localparam int LEN_W         = 5;
    localparam int CH_W          = 7;
    localparam int CFG_DATA_W    = 64;
    localparam int CFG_IDX_W     = 2;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_PAT_LOW  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PAT_HIGH = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PAT_LEN  = 2'd2;

    // reset pattern is a single star
    localparam logic [CFG_DATA_W-1:0] PAT_LOW_RST  = 64'd42;
    localparam logic [CFG_DATA_W-1:0] PAT_HIGH_RST = 64'd0;
    localparam logic [LEN_W-1:0]      PAT_LEN_RST  = 5'd1;

    // pattern characters
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_ANY   = 8'h3F;
    localparam logic [7:0] CH_OPEN  = 8'h5B;
    localparam logic [7:0] CH_CLOSE = 8'h5D;
    localparam logic [7:0] CH_DASH  = 8'h2D;
    localparam logic [7:0] CH_NUL   = 8'h00;

    typedef logic [PAT_BYTES-1:0][7:0] pat_bytes_t;

    typedef enum logic [1:0] {
        TH_PARSE,
        TH_RANGE,
        TH_CLOSED,
        TH_FAIL
    } th_mode_t;

    // parse state of the class opened at one pattern position
    typedef struct packed {
        th_mode_t         mode;
        logic             last_le;
        logic             hit;
        logic [LEN_W-1:0] close_pos;
    } cls_thread_t;

    localparam cls_thread_t THREAD_INIT = '{
        mode:      TH_PARSE,
        last_le:   1'b0,
        hit:       1'b0,
        close_pos: '0
    };

    typedef struct packed {
        logic [CH_W-1:0] ch;
        logic            is_end;
    } item_t;

endpackage
`default_nettype wire

// ----- rtl/gwm_if.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gwm_if
// Valid/ready channels of the wildcard matcher: text in, match flag out.
// ----------------------------------------------------------------------------
interface gwm_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] text_byte;
    logic       is_end;

    modport source (output valid, output text_byte, output is_end, input ready);
    modport sink   (input valid, input text_byte, input is_end, output ready);
endinterface

interface gwm_out_if;
    logic valid;
    logic ready;
    logic matched;

    modport source (output valid, output matched, input ready);
    modport sink   (input valid, input matched, output ready);
endinterface
`default_nettype wire

// ----- rtl/gwm_cell.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gwm_cell
// One cell of the class chain: applies pattern byte CELL_IDX to the bracket
// class parse of every earlier position, then registers item and state.
// ----------------------------------------------------------------------------
module gwm_cell #(
    parameter int CELL_IDX = 1,
    parameter int NUM_THR  = 16
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  en,
    input  logic                                  vld_in,
    input  gwm_pkg::item_t                        item_in,
    input  gwm_pkg::cls_thread_t [NUM_THR-1:0]    thr_in,
    input  logic [7:0]                            pat_char,
    input  logic [gwm_pkg::LEN_W-1:0]             eff_len,
    output logic                                  vld_out,
    output gwm_pkg::item_t                        item_out,
    output gwm_pkg::cls_thread_t [NUM_THR-1:0]    thr_out
);
    import gwm_pkg::*;

    logic                            vld_reg;
    item_t                           item_reg;
    cls_thread_t [NUM_THR-1:0]       thr_reg;
    cls_thread_t [NUM_THR-1:0]       thr_next;

    logic       char_used;
    logic       dash_at_end;
    logic [7:0] ch8;
    logic       single_le;
    logic       single_eq;
    logic       range_hi;

    always_comb
    begin
        char_used   = LEN_W'(CELL_IDX) < eff_len;
        dash_at_end = LEN_W'(CELL_IDX + 1) >= eff_len;
        ch8         = {1'b0, item_in.ch};
        single_le   = pat_char <= ch8;
        single_eq   = pat_char == ch8;
        range_hi    = ch8 <= pat_char;
    end

    always_comb
    begin
        thr_next = thr_in;
        for (int j = 0; j < NUM_THR; j++)
        begin
            // only classes opened before this byte see it
            if (j < CELL_IDX)
            begin
                case (thr_in[j].mode)
                    TH_PARSE:
                    begin
                        if (!char_used)
                        begin
                            thr_next[j].mode = TH_FAIL;
                        end
                        else if (pat_char == CH_CLOSE)
                        begin
                            thr_next[j].mode      = TH_CLOSED;
                            thr_next[j].close_pos = LEN_W'(CELL_IDX + 1);
                        end
                        else if (pat_char == CH_DASH)
                        begin
                            thr_next[j].mode = dash_at_end ? TH_FAIL : TH_RANGE;
                        end
                        else
                        begin
                            thr_next[j].last_le = single_le;
                            thr_next[j].hit     = thr_in[j].hit | single_eq;
                        end
                    end
                    TH_RANGE:
                    begin
                        // range start is the last single char, end is this byte
                        thr_next[j].hit  = thr_in[j].hit | (thr_in[j].last_le & range_hi);
                        thr_next[j].mode = TH_PARSE;
                    end
                    default:
                    begin
                        thr_next[j] = thr_in[j];
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else if (en)
        begin
            vld_reg <= vld_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            item_reg <= item_in;
            thr_reg  <= thr_next;
        end
    end

    assign vld_out  = vld_reg;
    assign item_out = item_reg;
    assign thr_out  = thr_reg;

endmodule
`default_nettype wire

// ----- rtl/gwm_update.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gwm_update
// Active pattern position set: star closure, one step per text char, and
// the match decision on the end item.
// ----------------------------------------------------------------------------
module gwm_update #(
    parameter int PATTERN_MAX = 16,
    parameter int NUM_THR     = 16
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  en,
    input  logic                                  vld,
    input  gwm_pkg::item_t                        item,
    input  gwm_pkg::cls_thread_t [NUM_THR-1:0]    thr,
    input  gwm_pkg::pat_bytes_t                   pat,
    input  logic [gwm_pkg::LEN_W-1:0]             eff_len,
    output logic                                  res_push,
    output logic                                  res_matched
);
    import gwm_pkg::*;

    localparam int ACT_W = PATTERN_MAX + 1;
    localparam int IDX_W = $clog2(ACT_W);

    logic [ACT_W-1:0] active_reg;
    logic [ACT_W-1:0] active_next;
    logic [ACT_W-1:0] len_mask;
    logic [ACT_W-1:0] cur;
    logic [ACT_W-1:0] reach;
    logic [ACT_W-1:0] step;
    logic [IDX_W-1:0] len_idx;
    logic [IDX_W-1:0] prev_idx;
    logic [LEN_W-1:0] len_m1;
    logic             end_match;

    always_comb
    begin
        for (int t = 0; t < ACT_W; t++)
        begin
            len_mask[t] = LEN_W'(t) <= eff_len;
        end
        cur      = active_reg & len_mask;
        len_idx  = eff_len[IDX_W-1:0];
        prev_idx = len_idx - IDX_W'(1);
        len_m1   = eff_len - LEN_W'(1);

        // a trailing star still open at the end of the text matches
        end_match = cur[len_idx] ||
                    ((eff_len != '0) && cur[prev_idx] &&
                     (pat[len_m1[PAT_IDX_W-1:0]] == CH_STAR));

        // stars let a position also stand on the byte after them
        reach = cur;
        for (int j = 0; j < PATTERN_MAX; j++)
        begin
            if (reach[j] && (LEN_W'(j) < eff_len) && (pat[j] == CH_STAR))
            begin
                reach[j+1] = 1'b1;
            end
        end

        step = '0;
        for (int j = 0; j < PATTERN_MAX; j++)
        begin
            if (reach[j] && (LEN_W'(j) < eff_len))
            begin
                case (pat[j])
                    CH_STAR:
                    begin
                        step[j] = 1'b1;
                    end
                    CH_ANY:
                    begin
                        step[j+1] = 1'b1;
                    end
                    CH_OPEN:
                    begin
                        if ((thr[j].mode == TH_CLOSED) && thr[j].hit)
                        begin
                            step = step | (ACT_W'(1) << thr[j].close_pos);
                        end
                    end
                    default:
                    begin
                        if (pat[j][CH_W-1:0] == item.ch)
                        begin
                            step[j+1] = 1'b1;
                        end
                    end
                endcase
            end
        end

        active_next = item.is_end ? ACT_W'(1) : step;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= ACT_W'(1);
        end
        else if (en && vld)
        begin
            active_reg <= active_next;
        end
    end

    assign res_push    = en && vld && item.is_end;
    assign res_matched = end_match;

endmodule
`default_nettype wire

// ----- rtl/glob_wildcard_matcher_unit.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// glob_wildcard_matcher_unit
// Streams text against a shell-style wildcard pattern of up to 16 bytes
// and reports a match flag on every end-of-text item.
// ----------------------------------------------------------------------------
// path: an end item's flag passes the input register, PATTERN_MAX-1 class
//   cells and the position update, then waits in the result buffer
// throughput: one item per cycle; the chain stalls only when an end item
//   reaches the update stage while the two-entry result buffer is full
// reset: pattern "*" of length 1, only position 0 active, chain and buffer empty
module glob_wildcard_matcher_unit #(
    parameter int PATTERN_MAX = gwm_pkg::PATTERN_MAX_C
) (
    input  logic                              clk,
    input  logic                              rst_n,
    gwm_in_if.sink                            txt,
    gwm_out_if.source                         res,
    input  logic                              cfg_we,
    input  logic [gwm_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [gwm_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import gwm_pkg::*;

    // configuration
    logic [CFG_DATA_W-1:0] pat_low_reg;
    logic [CFG_DATA_W-1:0] pat_high_reg;
    logic [LEN_W-1:0]      pat_len_reg;
    logic [LEN_W-1:0]      eff_len_reg;
    logic [LEN_W-1:0]      eff_len_next;
    logic [LEN_W-1:0]      len_clamped;
    pat_bytes_t            pat;

    // cell chain
    logic                         en;
    logic                         stg0_vld_reg;
    item_t                        stg0_item_reg;
    logic                         stg_vld  [PATTERN_MAX];
    item_t                        stg_item [PATTERN_MAX];
    cls_thread_t [PATTERN_MAX-1:0] stg_thr [PATTERN_MAX];

    // result buffer
    logic       res_push;
    logic       res_matched;
    logic       buf_mem_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] buf_cnt_reg;
    logic [1:0] buf_cnt_next;
    logic       buf_full;
    logic       pop;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pat_low_reg  <= PAT_LOW_RST;
            pat_high_reg <= PAT_HIGH_RST;
            pat_len_reg  <= PAT_LEN_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_PAT_LOW:  pat_low_reg  <= cfg_data;
                REG_PAT_HIGH: pat_high_reg <= cfg_data;
                REG_PAT_LEN:  pat_len_reg  <= cfg_data[LEN_W-1:0];
                default:      ;
            endcase
        end
    end

    assign pat = {pat_high_reg, pat_low_reg};

    // a zero byte ends the pattern early
    always_comb
    begin
        len_clamped  = (pat_len_reg > LEN_W'(PATTERN_MAX)) ? LEN_W'(PATTERN_MAX)
                                                           : pat_len_reg;
        eff_len_next = len_clamped;
        for (int i = PAT_BYTES - 1; i >= 0; i--)
        begin
            if ((LEN_W'(i) < len_clamped) && (pat[i] == CH_NUL))
            begin
                eff_len_next = LEN_W'(i);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            eff_len_reg <= PAT_LEN_RST;
        end
        else
        begin
            eff_len_reg <= eff_len_next;
        end
    end

    // chain moves unless a flag has nowhere to go
    assign buf_full  = buf_cnt_reg == 2'd2;
    assign en        = !(stg_vld[PATTERN_MAX-1] && stg_item[PATTERN_MAX-1].is_end && buf_full);
    assign txt.ready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stg0_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            stg0_vld_reg <= txt.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            stg0_item_reg.ch     <= txt.text_byte[CH_W-1:0];
            stg0_item_reg.is_end <= txt.is_end;
        end
    end

    assign stg_vld[0]  = stg0_vld_reg;
    assign stg_item[0] = stg0_item_reg;
    assign stg_thr[0]  = {PATTERN_MAX{THREAD_INIT}};

    for (genvar s = 1; s < PATTERN_MAX; s++)
    begin : g_cell
        gwm_cell #(
            .CELL_IDX (s),
            .NUM_THR  (PATTERN_MAX)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .en       (en),
            .vld_in   (stg_vld[s-1]),
            .item_in  (stg_item[s-1]),
            .thr_in   (stg_thr[s-1]),
            .pat_char (pat[s]),
            .eff_len  (eff_len_reg),
            .vld_out  (stg_vld[s]),
            .item_out (stg_item[s]),
            .thr_out  (stg_thr[s])
        );
    end

    gwm_update #(
        .PATTERN_MAX (PATTERN_MAX),
        .NUM_THR     (PATTERN_MAX)
    ) u_update (
        .clk         (clk),
        .rst_n       (rst_n),
        .en          (en),
        .vld         (stg_vld[PATTERN_MAX-1]),
        .item        (stg_item[PATTERN_MAX-1]),
        .thr         (stg_thr[PATTERN_MAX-1]),
        .pat         (pat),
        .eff_len     (eff_len_reg),
        .res_push    (res_push),
        .res_matched (res_matched)
    );

    // two-entry result buffer
    assign pop          = res.valid && res.ready;
    assign buf_cnt_next = buf_cnt_reg + {1'b0, res_push} - {1'b0, pop};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            buf_cnt_reg <= 2'd0;
            wr_ptr_reg  <= 1'b0;
            rd_ptr_reg  <= 1'b0;
        end
        else
        begin
            buf_cnt_reg <= buf_cnt_next;
            if (res_push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_push)
        begin
            buf_mem_reg[wr_ptr_reg] <= res_matched;
        end
    end

    assign res.valid   = buf_cnt_reg != 2'd0;
    assign res.matched = buf_mem_reg[rd_ptr_reg];

endmodule
`default_nettype wire

// ----- rtl/gwm_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gwm_checker
// Port-level checks of the wildcard matcher: every flag belongs to an end
// item, flags hold while stalled, quiet output under reset.
// ----------------------------------------------------------------------------
module gwm_checker #(
    parameter int PATTERN_MAX = 16
) (
    input logic clk,
    input logic rst_n,
    input logic in_valid,
    input logic in_ready,
    input logic in_is_end,
    input logic out_valid,
    input logic out_ready,
    input logic out_matched
);
    // end items in the chain plus the result buffer
    localparam int PEND_MAX = PATTERN_MAX + 2;
    localparam int PEND_W   = $clog2(PEND_MAX + 2) + 1;

    logic [PEND_W-1:0] pend_cnt_reg;
    logic [PEND_W-1:0] pend_cnt_next;
    logic              end_xfer;
    logic              out_xfer;

    assign end_xfer      = in_valid && in_ready && in_is_end;
    assign out_xfer      = out_valid && out_ready;
    assign pend_cnt_next = pend_cnt_reg + PEND_W'(end_xfer) - PEND_W'(out_xfer);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_cnt_reg <= '0;
        end
        else
        begin
            pend_cnt_reg <= pend_cnt_next;
        end
    end

    a_quiet_in_reset: assert property (@(posedge clk) !rst_n |-> !out_valid)
        else $error("result valid during reset");

    a_flag_has_end: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (pend_cnt_reg != '0))
        else $error("result without an outstanding end item");

    a_pend_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        pend_cnt_reg <= PEND_W'(PEND_MAX))
        else $error("more end items outstanding than the chain can hold");

    a_flag_holds: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_matched))
        else $error("stalled result changed or dropped");

endmodule

bind glob_wildcard_matcher_unit gwm_checker #(
    .PATTERN_MAX (PATTERN_MAX)
) u_gwm_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (txt.valid),
    .in_ready    (txt.ready),
    .in_is_end   (txt.is_end),
    .out_valid   (res.valid),
    .out_ready   (res.ready),
    .out_matched (res.matched)
);
`default_nettype wire

// ----- dv/tb_glob_wildcard_matcher_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_glob_wildcard_matcher_unit
// Self-checking bench for the streamed wildcard matcher. Patterns are loaded
// through the register port while the block is idle. Texts are streamed with
// random gaps and output stalls. A bit-level predictor of the active pattern
// positions gives the expected match flag of every end item, and each flag
// is checked against it in order.
// ----------------------------------------------------------------------------
module tb_glob_wildcard_matcher_unit;

    import gwm_pkg::*;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = PATTERN_MAX_C + 8;
    localparam int HOLD_CYCLES  = 300;
    localparam int NO_LAST      = 'h7FFF;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

    typedef struct packed {
        logic [7:0] data;
        logic       is_end;
    } text_item_t;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    gwm_in_if  txt_if ();
    gwm_out_if res_if ();

    glob_wildcard_matcher_unit u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .txt       (txt_if),
        .res       (res_if),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // pending text items and expected match flags
    text_item_t text_q[$];
    logic       match_q[$];

    // predictor copy of the registers and of the position set
    logic [CFG_DATA_W-1:0] pat_lo;
    logic [CFG_DATA_W-1:0] pat_hi;
    logic [LEN_W-1:0]      pat_len;
    logic [16:0]           positions;

    int         queued_count;
    int         accepted_count;
    int         err_count;
    int         cycle_count;
    int         gap_cnt;
    int         stall_cnt;
    int         hold_cnt;
    logic       hold_done;
    logic       want_hold;
    logic       idle_on;
    logic       no_idle;
    text_item_t drv_item;
    logic       exp_match;

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    task automatic report_mismatch(input string what);
        $display("mismatch at cycle %0d: %s", cycle_count, what);
        err_count++;
    endtask

    // ------------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------------
    function automatic logic [7:0] pattern_byte(input int j);
        int          k;
        logic [63:0] w;
        k = j & 15;
        w = (k < 8) ? pat_lo : pat_hi;
        return w[(k % 8) * 8 +: 8];
    endfunction

    function automatic int effective_length();
        int n;
        n = int'(pat_len);
        if (n > PATTERN_MAX_C)
            n = PATTERN_MAX_C;
        for (int i = 0; i < n; i++)
            if (pattern_byte(i) == CH_NUL)
                return i;
        return n;
    endfunction

    // position after the class opened at j, or 0 when it misses or is unclosed
    function automatic int class_exit(input int j, input int len, input logic [6:0] ch);
        int         k;
        int         last;
        int         c;
        logic       hit;
        logic [7:0] b;
        k    = j + 1;
        last = NO_LAST;
        hit  = 1'b0;
        c    = int'(ch);
        while (k < len)
        begin
            b = pattern_byte(k);
            if (b == CH_CLOSE)
                return hit ? k + 1 : 0;
            if (b == CH_DASH)
            begin
                if (k + 1 >= len)
                    return 0;
                if (last <= c && c <= int'(pattern_byte(k + 1)))
                    hit = 1'b1;
                k += 2;
            end
            else
            begin
                last = int'(b);
                if (int'(b) == c)
                    hit = 1'b1;
                k++;
            end
        end
        return 0;
    endfunction

    function automatic logic [16:0] live_positions(input logic [16:0] act, input int len);
        logic [16:0] cur;
        cur = act;
        for (int j = len + 1; j < 17; j++)
            cur[j] = 1'b0;
        return cur;
    endfunction

    function automatic logic [16:0] next_positions(input logic [16:0] act,
                                                   input logic [6:0] ch);
        int          len;
        int          n;
        logic [16:0] cur;
        logic [16:0] nxt;
        logic [7:0]  b;
        len = effective_length();
        cur = live_positions(act, len);
        nxt = '0;
        // a star may also match the empty run
        for (int j = 0; j < len; j++)
            if (cur[j] && pattern_byte(j) == CH_STAR)
                cur[j + 1] = 1'b1;
        for (int j = 0; j < len; j++)
        begin
            if (cur[j])
            begin
                b = pattern_byte(j);
                if (b == CH_STAR)
                    nxt[j] = 1'b1;
                else if (b == CH_ANY)
                    nxt[j + 1] = 1'b1;
                else if (b == CH_OPEN)
                begin
                    n = class_exit(j, len, ch);
                    if (n != 0 && n <= len)
                        nxt[n] = 1'b1;
                end
                else if (b[6:0] == ch)
                    nxt[j + 1] = 1'b1;
            end
        end
        return nxt;
    endfunction

    function automatic logic end_matches(input logic [16:0] act);
        int          len;
        logic [16:0] cur;
        logic        m;
        len = effective_length();
        cur = live_positions(act, len);
        m   = cur[len];
        if (len > 0 && cur[len - 1] && pattern_byte(len - 1) == CH_STAR)
            m = 1'b1;
        return m;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pat_lo  = PAT_LOW_RST;
            pat_hi  = PAT_HIGH_RST;
            pat_len = PAT_LEN_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_PAT_LOW:  pat_lo  = cfg_data;
                REG_PAT_HIGH: pat_hi  = cfg_data;
                REG_PAT_LEN:  pat_len = cfg_data[LEN_W-1:0];
                default:      ;
            endcase
        end
    end

    // ------------------------------------------------------------------------
    // text driver
    // ------------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            txt_if.valid     <= 1'b0;
            txt_if.text_byte <= '0;
            txt_if.is_end    <= 1'b0;
            gap_cnt   = 0;
            positions = 17'd1;
        end
        else
        begin
            if (txt_if.valid && txt_if.ready)
            begin
                accepted_count++;
                if (txt_if.is_end)
                begin
                    match_q.push_back(end_matches(positions));
                    positions = 17'd1;
                end
                else
                    positions = next_positions(positions, txt_if.text_byte[6:0]);
            end
            if (!txt_if.valid || txt_if.ready)
            begin
                if (gap_cnt > 0)
                begin
                    gap_cnt--;
                    txt_if.valid <= 1'b0;
                end
                else if (text_q.size() != 0 && idle_on && !no_idle &&
                         $urandom_range(0, 5) == 0)
                begin
                    gap_cnt = $urandom_range(0, 4);
                    txt_if.valid <= 1'b0;
                end
                else if (text_q.size() != 0)
                begin
                    drv_item = text_q.pop_front();
                    txt_if.valid     <= 1'b1;
                    txt_if.text_byte <= drv_item.data;
                    txt_if.is_end    <= drv_item.is_end;
                end
                else
                    txt_if.valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------------
    // result monitor
    // ------------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            hold_cnt <= 0;
        else if (hold_cnt > 0)
            hold_cnt <= hold_cnt - 1;
        else if (want_hold && !hold_done)
            hold_cnt <= HOLD_CYCLES;
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            hold_done <= 1'b0;
        else if (hold_cnt > 0)
            hold_done <= 1'b1;
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_if.ready <= 1'b0;
            stall_cnt = 0;
        end
        else
        begin
            if (res_if.valid && res_if.ready)
            begin
                if (match_q.size() == 0)
                    report_mismatch($sformatf("unexpected result, matched %0b",
                                              res_if.matched));
                else
                begin
                    exp_match = match_q.pop_front();
                    if (res_if.matched !== exp_match)
                        report_mismatch($sformatf("matched %0b, expected %0b",
                                                  res_if.matched, exp_match));
                end
            end
            if (stall_cnt > 0)
            begin
                stall_cnt--;
                res_if.ready <= 1'b0;
            end
            else if (hold_cnt > 0)
                res_if.ready <= 1'b0;
            else if (idle_on && !no_idle && $urandom_range(0, 5) == 0)
            begin
                stall_cnt = $urandom_range(0, 4);
                res_if.ready <= 1'b0;
            end
            else
                res_if.ready <= 1'b1;
        end
    end

    // ------------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------------
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] val);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    task automatic load_pattern(input logic [127:0] pb, input logic [LEN_W-1:0] len);
        write_reg(REG_PAT_LOW, pb[63:0]);
        write_reg(REG_PAT_HIGH, pb[127:64]);
        write_reg(REG_PAT_LEN, {{(CFG_DATA_W-LEN_W){1'b0}}, len});
    endtask

    function automatic logic [127:0] pack_str(input string s);
        logic [127:0] r;
        r = '0;
        for (int i = 0; i < s.len() && i < 16; i++)
            r[i * 8 +: 8] = s[i];
        return r;
    endfunction

    task automatic push_text(input logic [7:0] b);
        text_q.push_back('{data: b, is_end: 1'b0});
        queued_count++;
    endtask

    task automatic push_end();
        logic [7:0] junk;
        junk = 8'($urandom_range(0, 255));
        text_q.push_back('{data: junk, is_end: 1'b1});
        queued_count++;
    endtask

    function automatic logic [7:0] alpha_char();
        logic [7:0] c;
        c = "a";
        return c + 8'($urandom_range(0, 3));
    endfunction

    function automatic logic [7:0] rand_char();
        logic [7:0] c;
        if ($urandom_range(0, 3) != 0)
        begin
            c    = alpha_char();
            c[7] = 1'($urandom_range(0, 1));
        end
        else
            c = 8'($urandom_range(0, 255));
        return c;
    endfunction

    // wait until every item is taken and every flag is back, then let the chain empty
    task automatic wait_drained();
        while (accepted_count != queued_count || match_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic gen_pattern(output logic [127:0] pb, output logic [LEN_W-1:0] len);
        logic [7:0] bq[$];
        logic [7:0] c;
        int         elems;
        int         parts;
        int         r;
        for (int i = 0; i < 16; i++)
            pb[i * 8 +: 8] = 8'($urandom_range(0, 255));
        elems = $urandom_range(1, 8);
        for (int e = 0; e < elems; e++)
        begin
            case ($urandom_range(0, 9))
                0, 1, 2:
                begin
                    c = alpha_char();
                    if ($urandom_range(0, 3) == 0)
                        c[7] = 1'b1;
                    bq.push_back(c);
                end
                3, 4: bq.push_back(CH_STAR);
                5:    bq.push_back(CH_ANY);
                6, 7:
                begin
                    bq.push_back(CH_OPEN);
                    parts = $urandom_range(1, 2);
                    for (int p = 0; p < parts; p++)
                    begin
                        case ($urandom_range(0, 4))
                            0, 1: bq.push_back(alpha_char());
                            2:
                            begin
                                bq.push_back(alpha_char());
                                bq.push_back(CH_DASH);
                                bq.push_back(alpha_char());
                            end
                            3:
                            begin
                                bq.push_back(8'($urandom_range(128, 255)));
                                if ($urandom_range(0, 1) == 0)
                                begin
                                    bq.push_back(CH_DASH);
                                    bq.push_back(8'($urandom_range(128, 255)));
                                end
                            end
                            default:
                            begin
                                bq.push_back(CH_DASH);
                                bq.push_back(alpha_char());
                            end
                        endcase
                    end
                    // sometimes leave the class open
                    if ($urandom_range(0, 5) != 0)
                        bq.push_back(CH_CLOSE);
                end
                8: bq.push_back(8'($urandom_range(1, 255)));
                default:
                    bq.push_back(($urandom_range(0, 2) == 0) ? CH_NUL : alpha_char());
            endcase
        end
        for (int i = 0; i < bq.size() && i < 16; i++)
            pb[i * 8 +: 8] = bq[i];
        r = $urandom_range(0, 14);
        if (r == 0)
            len = 5'd0;
        else if (r == 1)
            len = LEN_W'($urandom_range(17, 31));
        else if (r == 2)
            len = 5'd16;
        else if (r == 3)
        begin
            pb  = '1;
            len = 5'd16;
        end
        else if (r == 4)
        begin
            pb  = '0;
            len = LEN_W'($urandom_range(0, 31));
        end
        else
            len = LEN_W'((bq.size() > 16) ? 16 : bq.size());
    endtask

    // a text that follows the pattern element by element, so matches are common
    task automatic push_pattern_text(input logic [127:0] pb, input logic [LEN_W-1:0] len);
        logic [7:0] picks[$];
        logic [7:0] b;
        logic [7:0] c;
        int         n;
        int         j;
        int         k;
        n = (len > 5'd16) ? 16 : int'(len);
        j = 0;
        while (j < n)
        begin
            b = pb[j * 8 +: 8];
            if (b == CH_NUL)
                break;
            if (b == CH_STAR)
            begin
                repeat ($urandom_range(0, 3)) push_text(rand_char());
                j++;
            end
            else if (b == CH_OPEN)
            begin
                picks.delete();
                k = j + 1;
                while (k < n && pb[k * 8 +: 8] != CH_CLOSE)
                begin
                    if (pb[k * 8 +: 8] != CH_DASH)
                        picks.push_back(pb[k * 8 +: 8]);
                    k++;
                end
                if (picks.size() != 0 && $urandom_range(0, 4) != 0)
                begin
                    c    = picks[$urandom_range(0, picks.size() - 1)];
                    c[7] = 1'($urandom_range(0, 1));
                    push_text(c);
                end
                else
                    push_text(rand_char());
                j = k + 1;
            end
            else if (b == CH_ANY)
            begin
                push_text(rand_char());
                j++;
            end
            else
            begin
                c    = b;
                c[7] = 1'($urandom_range(0, 1));
                push_text(c);
                j++;
            end
        end
        if ($urandom_range(0, 5) == 0)
            push_text(rand_char());
        push_end();
    endtask

    // ------------------------------------------------------------------------
    // test sequence
    // ------------------------------------------------------------------------
    initial
    begin
        logic [127:0]     pb;
        logic [LEN_W-1:0] len;
        int               phase_n;
        rst_n            = 1'b0;
        cfg_we           = 1'b0;
        cfg_index        = '0;
        cfg_data         = '0;
        want_hold        = 1'b0;
        idle_on          = 1'b1;
        no_idle          = 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset pattern is a lone star: empty text, zero character
        push_end();
        push_text(8'h00);
        push_end();
        wait_drained();

        // length above the maximum, cut short by a zero byte
        load_pattern(pack_str("a*?[b-d]"), 5'd31);
        push_text("a");
        push_text("q");
        push_text(8'hE2);
        push_end();
        wait_drained();

        // high bytes inside classes: lone high byte, empty range, range end to 127
        pb = pack_str("[?b][?-zc][a-?]*");
        pb[1 * 8 +: 8]  = 8'h85;
        pb[5 * 8 +: 8]  = 8'hF0;
        pb[13 * 8 +: 8] = 8'hC0;
        load_pattern(pb, 5'd16);
        push_text("b");
        push_text("c");
        push_text(8'hFF);
        push_end();
        push_text("a");
        push_end();
        wait_drained();

        // empty pattern
        load_pattern(pack_str("abc"), 5'd0);
        push_end();
        push_text("a");
        push_end();
        wait_drained();

        // star not last at end of text, class left open by a trailing dash
        load_pattern(pack_str("a*[c-"), 5'd5);
        push_text("a");
        push_end();
        push_text("a");
        push_text("c");
        push_end();
        wait_drained();

        // dash with no single character before it; text left open for the next load
        load_pattern(pack_str("[-a]b"), 5'd5);
        push_text("a");
        push_text("b");
        push_end();
        push_text("b");
        wait_drained();

        phase_n = 0;
        while (queued_count < 830)
        begin
            phase_n++;
            gen_pattern(pb, len);
            if ($urandom_range(0, 7) == 0)
                write_reg(REG_UNUSED, {$urandom, $urandom});
            load_pattern(pb, len);
            idle_on = ($urandom_range(0, 3) != 0);
            if (queued_count > 700)
                no_idle = 1'b1;
            if (phase_n == 4)
            begin
                // output held off while ends keep coming, so the block backs up
                idle_on   = 1'b0;
                want_hold = 1'b1;
                for (int i = 0; i < 60; i++)
                begin
                    if ($urandom_range(0, 3) == 0)
                        push_text(rand_char());
                    push_end();
                end
            end
            else
            begin
                repeat ($urandom_range(3, 8))
                begin
                    case ($urandom_range(0, 9))
                        0, 1, 2, 3, 4, 5: push_pattern_text(pb, len);
                        6, 7, 8:
                        begin
                            repeat ($urandom_range(0, 10)) push_text(rand_char());
                            push_end();
                        end
                        default: push_end();
                    endcase
                end
            end
            // sometimes stop mid-text, so the next load lands on live positions
            if ($urandom_range(0, 4) == 0)
                repeat ($urandom_range(1, 4)) push_text(rand_char());
            wait_drained();
        end

        if (err_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

// ----- files.f -----
rtl/gwm_pkg.sv
rtl/gwm_if.sv
rtl/gwm_cell.sv
rtl/gwm_update.sv
rtl/glob_wildcard_matcher_unit.sv
rtl/gwm_checker.sv
dv/tb_glob_wildcard_matcher_unit.sv
